### rtl/matrix_line_run_sum_search_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the matrix line run-sum search block
// Each macro expects clk and arst_n in the scope where it is used.
// ---------------------------------------------------------------------------
`ifndef MATRIX_LINE_RUN_SUM_SEARCH_DEFINES_SVH
`define MATRIX_LINE_RUN_SUM_SEARCH_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MLRS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define MLRS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/mlrs_pkg.sv
// ---------------------------------------------------------------------------
// mlrs_pkg
// Types and fixed field widths shared by the run-sum search files.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mlrs_pkg;

	// fixed field widths
	localparam int ELEM_W     = 16;
	localparam int TARGET_W   = 32;
	localparam int SUM_W      = 33;
	localparam int CNT_REG_W  = 7;
	localparam int POS_OUT_W  = 6;
	localparam int COUNT_W    = 14;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// register values after reset
	localparam logic [TARGET_W-1:0] RESET_TARGET = 32'd1;
	localparam int                  RESET_COUNT  = 64;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_HREQ,
		ST_HSUB,
		ST_VREQ,
		ST_VSUB,
		ST_DONE
	} mlrs_state_t;

endpackage

### rtl/mlrs_elem_if.sv
// ---------------------------------------------------------------------------
// mlrs_elem_if
// Element channel: one matrix element per word, row-major order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mlrs_elem_if import mlrs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ELEM_W-1:0] element_value;

	modport source (output valid, output element_value, input ready);
	modport sink   (input valid, input element_value, output ready);
endinterface

### rtl/mlrs_result_if.sv
// ---------------------------------------------------------------------------
// mlrs_result_if
// Result channel: one word per element with run hits and running count.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mlrs_result_if import mlrs_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [POS_OUT_W-1:0] cell_row;
	logic [POS_OUT_W-1:0] cell_col;
	logic                 h_found;
	logic [POS_OUT_W-1:0] h_start_col;
	logic                 v_found;
	logic [POS_OUT_W-1:0] v_start_row;
	logic [COUNT_W-1:0]   match_count;
	logic                 last_cell;

	modport source (
		output valid, output cell_row, output cell_col, output h_found,
		output h_start_col, output v_found, output v_start_row,
		output match_count, output last_cell, input ready
	);
	modport sink (
		input valid, input cell_row, input cell_col, input h_found,
		input h_start_col, input v_found, input v_start_row,
		input match_count, input last_cell, output ready
	);
endinterface

### rtl/mlrs_ram.sv
// ---------------------------------------------------------------------------
// mlrs_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mlrs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/matrix_line_run_sum_search.sv
// ---------------------------------------------------------------------------
// matrix_line_run_sum_search
// Finds horizontal and vertical runs summing to a target, by end cell.
//
//   channel   dir   word / fields
//   element   in    element_value
//   result    out   cell_row cell_col h_found h_start_col v_found
//                   v_start_row match_count last_cell
//   cfg_*     in    write enable, register index, write data
//
// An element is accepted in idle, then passes load, row request, column
// request and done. Each element dropped from the row or column window adds
// a read and a subtract step, and is dropped at most once per window; the
// single read port of the element store sets this: each drop reads one word.
// Reset is asynchronous; the element store needs no clearing pass. A stalled
// result is held in its output register while the next element is worked.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "matrix_line_run_sum_search_defines.svh"

module matrix_line_run_sum_search import mlrs_pkg::*; #(
	parameter int MAX_ROWS    = 64,
	parameter int MAX_COLS    = 64,
	parameter int VALUE_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	mlrs_elem_if.sink             element,
	mlrs_result_if.source         result
);

	localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RCW    = $clog2(MAX_ROWS + 1);
	localparam int CCW    = $clog2(MAX_COLS + 1);
	localparam int DEPTH  = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int VIN_W  = (VALUE_WIDTH < ELEM_W) ? VALUE_WIDTH : ELEM_W;
	localparam int CWIN_W = SUM_W + RCW;
	localparam int RST_ROWS = (MAX_ROWS < RESET_COUNT) ? MAX_ROWS : RESET_COUNT;
	localparam int RST_COLS = (MAX_COLS < RESET_COUNT) ? MAX_COLS : RESET_COUNT;

	function automatic logic [RCW-1:0] clamp_rows(input logic [CNT_REG_W-1:0] v);
		logic [RCW-1:0] res;
		if (v == '0) begin
			res = RCW'(1);
		end else if (32'(v) > MAX_ROWS) begin
			res = RCW'(MAX_ROWS);
		end else begin
			res = RCW'(v);
		end
		return res;
	endfunction

	function automatic logic [CCW-1:0] clamp_cols(input logic [CNT_REG_W-1:0] v);
		logic [CCW-1:0] res;
		if (v == '0) begin
			res = CCW'(1);
		end else if (32'(v) > MAX_COLS) begin
			res = CCW'(MAX_COLS);
		end else begin
			res = CCW'(v);
		end
		return res;
	endfunction

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [RW-1:0] r,
			input logic [CW-1:0] c);
		return ADDR_W'(int'(r) * MAX_COLS + int'(c));
	endfunction

	// configuration
	logic [TARGET_W-1:0] target_q;
	logic [RCW-1:0]      row_cnt_q;
	logic [CCW-1:0]      col_cnt_q;

	// position and windows
	logic [RW-1:0]       cur_row_q;
	logic [CW-1:0]       cur_col_q;
	logic [COUNT_W-1:0]  match_q;
	logic [SUM_W-1:0]    rsum_q;
	logic [CCW-1:0]      rstart_q;
	logic [SUM_W-1:0]    csum_q;
	logic [RCW-1:0]      cstart_q;
	logic [VALUE_WIDTH-1:0] v_s1;

	mlrs_state_t st_q, st_d;

	// output register
	logic                 out_valid_q;
	logic [POS_OUT_W-1:0] o_row_q, o_col_q, o_hstart_q, o_vstart_q;
	logic                 o_hf_q, o_vf_q, o_last_q;
	logic [COUNT_W-1:0]   o_count_q;

	// memory ports
	logic                   st_we, st_re;
	logic [ADDR_W-1:0]      st_waddr, st_raddr;
	logic [VALUE_WIDTH-1:0] st_rdata;
	logic                   cw_we, cw_re;
	logic [CW-1:0]          cw_addr;
	logic [CWIN_W-1:0]      cw_rdata;

	// control
	logic                   accept, done_go, h_drop, v_drop;
	logic [VALUE_WIDTH-1:0] v_in;
	logic [SUM_W-1:0]       t_ext;
	logic [CCW-1:0]         c_ext;
	logic [RCW-1:0]         r_ext;
	logic                   hf, vf, last, row_end;

	assign v_in    = VALUE_WIDTH'(element.element_value[VIN_W-1:0]);
	assign t_ext   = SUM_W'(target_q);
	assign c_ext   = CCW'(cur_col_q);
	assign r_ext   = RCW'(cur_row_q);
	assign accept  = element.valid && element.ready;
	assign h_drop  = (rsum_q > t_ext) && (rstart_q <= c_ext);
	assign v_drop  = (csum_q > t_ext) && (cstart_q <= r_ext);
	assign hf      = (rsum_q == t_ext) && (rstart_q <= c_ext);
	assign vf      = (csum_q == t_ext) && (cstart_q <= r_ext);
	assign row_end = (CCW'(cur_col_q) + CCW'(1)) >= col_cnt_q;
	assign last    = row_end && ((RCW'(cur_row_q) + RCW'(1)) >= row_cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d          = st_q;
		element.ready = 1'b0;
		done_go       = 1'b0;
		st_re         = 1'b0;
		st_raddr      = cell_addr(cur_row_q, CW'(rstart_q));
		unique case (st_q)
			ST_IDLE: begin
				element.ready = 1'b1;
				if (element.valid) begin
					st_d = ST_LOAD;
				end
			end
			ST_LOAD: st_d = ST_HREQ;
			ST_HREQ: begin
				if (h_drop) begin
					st_re = 1'b1;
					st_d  = ST_HSUB;
				end else begin
					st_d = ST_VREQ;
				end
			end
			ST_HSUB: st_d = ST_HREQ;
			ST_VREQ: begin
				st_raddr = cell_addr(RW'(cstart_q), cur_col_q);
				if (v_drop) begin
					st_re = 1'b1;
					st_d  = ST_VSUB;
				end else begin
					st_d = ST_DONE;
				end
			end
			ST_VSUB: st_d = ST_VREQ;
			ST_DONE: begin
				// hold until the output register is free
				if (!out_valid_q || result.ready) begin
					done_go = 1'b1;
					st_d    = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	assign st_we    = accept;
	assign st_waddr = cell_addr(cur_row_q, cur_col_q);
	assign cw_re    = accept;
	assign cw_we    = done_go;
	assign cw_addr  = cur_col_q;

	mlrs_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (DEPTH)
	) u_elem_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (v_in),
		.re    (st_re),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	mlrs_ram #(
		.WIDTH (CWIN_W),
		.DEPTH (MAX_COLS)
	) u_col_win (
		.clk   (clk),
		.we    (cw_we),
		.waddr (cw_addr),
		.wdata ({csum_q, cstart_q}),
		.re    (cw_re),
		.raddr (cw_addr),
		.rdata (cw_rdata)
	);

	// configuration, position, row window and running count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q  <= RESET_TARGET;
			row_cnt_q <= RCW'(RST_ROWS);
			col_cnt_q <= CCW'(RST_COLS);
			cur_row_q <= '0;
			cur_col_q <= '0;
			match_q   <= '0;
			rsum_q    <= '0;
			rstart_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TARGET: target_q  <= cfg_data;
				CFG_ROWS:   row_cnt_q <= clamp_rows(cfg_data[CNT_REG_W-1:0]);
				CFG_COLS:   col_cnt_q <= clamp_cols(cfg_data[CNT_REG_W-1:0]);
				default: ;
			endcase
			// any known register aborts the matrix
			if (cfg_index == CFG_TARGET || cfg_index == CFG_ROWS ||
					cfg_index == CFG_COLS) begin
				cur_row_q <= '0;
				cur_col_q <= '0;
				match_q   <= '0;
				rsum_q    <= '0;
				rstart_q  <= '0;
			end
		end else begin
			if (accept) begin
				if (cur_col_q == '0) begin
					rsum_q   <= SUM_W'(v_in);
					rstart_q <= '0;
				end else begin
					rsum_q <= rsum_q + SUM_W'(v_in);
				end
			end else if (st_q == ST_HSUB) begin
				rsum_q   <= rsum_q - SUM_W'(st_rdata);
				rstart_q <= rstart_q + CCW'(1);
			end
			if (done_go) begin
				if (last) begin
					cur_row_q <= '0;
					cur_col_q <= '0;
					match_q   <= '0;
					rsum_q    <= '0;
					rstart_q  <= '0;
				end else begin
					match_q <= match_q + COUNT_W'(hf) + COUNT_W'(vf);
					if (row_end) begin
						cur_col_q <= '0;
						cur_row_q <= cur_row_q + RW'(1);
					end else begin
						cur_col_q <= cur_col_q + CW'(1);
					end
				end
			end
		end
	end

	// column window working copy
	always_ff @(posedge clk) begin
		if (accept) begin
			v_s1 <= v_in;
		end
		if (st_q == ST_LOAD) begin
			if (cur_row_q == '0) begin
				csum_q   <= SUM_W'(v_s1);
				cstart_q <= '0;
			end else begin
				csum_q   <= cw_rdata[CWIN_W-1 -: SUM_W] + SUM_W'(v_s1);
				cstart_q <= cw_rdata[RCW-1:0];
			end
		end else if (st_q == ST_VSUB) begin
			csum_q   <= csum_q - SUM_W'(st_rdata);
			cstart_q <= cstart_q + RCW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_go) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_go) begin
			o_row_q    <= POS_OUT_W'(cur_row_q);
			o_col_q    <= POS_OUT_W'(cur_col_q);
			o_hf_q     <= hf;
			o_hstart_q <= hf ? POS_OUT_W'(rstart_q) : '0;
			o_vf_q     <= vf;
			o_vstart_q <= vf ? POS_OUT_W'(cstart_q) : '0;
			o_count_q  <= match_q + COUNT_W'(hf) + COUNT_W'(vf);
			o_last_q   <= last;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.cell_row    = o_row_q;
	assign result.cell_col    = o_col_q;
	assign result.h_found     = o_hf_q;
	assign result.h_start_col = o_hstart_q;
	assign result.v_found     = o_vf_q;
	assign result.v_start_row = o_vstart_q;
	assign result.match_count = o_count_q;
	assign result.last_cell   = o_last_q;

	`MLRS_ASSERT_NEXT(a_accept_loads, accept, st_q == ST_LOAD, "element word did not start a load")
	`MLRS_ASSERT_NEXT(a_last_restarts, done_go && last, cur_row_q == '0 && cur_col_q == '0 && match_q == '0, "matrix end did not restart position")
	`MLRS_ASSERT_NOW(a_row_start_bound, st_q != ST_IDLE, (CCW + 1)'(rstart_q) <= (CCW + 1)'(cur_col_q) + (CCW + 1)'(1), "row window start ran past the cell")
	`MLRS_ASSERT_NOW(a_row_shrunk, st_q == ST_DONE, rsum_q <= t_ext || rstart_q > c_ext, "row window left above target")
	`MLRS_ASSERT_NOW(a_col_shrunk, st_q == ST_DONE, csum_q <= t_ext || cstart_q > r_ext, "column window left above target")

endmodule

### dv/matrix_line_run_sum_search_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// matrix_line_run_sum_search_test
// Self-checking bench for the run-sum search block. Elements go in over the
// element channel while a scoreboard keeps its own row and column windows
// and predicts every result word. Each result word is checked field by field
// against the oldest prediction. Both channels idle and stall at random. The
// matrix size and the target are changed between phases, including count
// values out of range, a zero target and a full-scale target.
// ---------------------------------------------------------------------------

module matrix_line_run_sum_search_test;
	import mlrs_pkg::*;

	localparam int CLK_PERIOD   = 20;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 850;
	localparam int IDLE_PCT     = 26;
	localparam int HOLD_CYCLES  = 400;
	localparam int DIM_MAX      = 64;
	localparam int DRAIN_CYCLES = 20;

	// index with no register behind it
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef enum {MIX_SMALL, MIX_WIDE} value_mix_t;

	typedef struct packed {
		logic [POS_OUT_W-1:0] cell_row;
		logic [POS_OUT_W-1:0] cell_col;
		logic                 h_found;
		logic [POS_OUT_W-1:0] h_start_col;
		logic                 v_found;
		logic [POS_OUT_W-1:0] v_start_row;
		logic [COUNT_W-1:0]   match_count;
		logic                 last_cell;
	} cell_result_t;

	class run_sum_scoreboard;
		logic [TARGET_W-1:0] target;
		int                  rows;
		int                  cols;
		bit [ELEM_W-1:0]     store [DIM_MAX][DIM_MAX];
		longint              row_sum;
		int                  row_start;
		longint              col_sum [DIM_MAX];
		int                  col_start [DIM_MAX];
		int                  cur_row;
		int                  cur_col;
		logic [COUNT_W-1:0]  hits;
		cell_result_t        pending_q[$];
		int                  errors;

		function new();
			target = RESET_TARGET;
			rows   = RESET_COUNT;
			cols   = RESET_COUNT;
			errors = 0;
			restart();
		endfunction

		function void restart();
			row_sum   = 0;
			row_start = 0;
			cur_row   = 0;
			cur_col   = 0;
			hits      = '0;
			foreach (col_sum[i]) begin
				col_sum[i]   = 0;
				col_start[i] = 0;
			end
		endfunction

		function int clamp_count(logic [CNT_REG_W-1:0] v);
			if (v == 0)
				return 1;
			if (v > DIM_MAX)
				return DIM_MAX;
			return v;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_TARGET: target = data[TARGET_W-1:0];
				CFG_ROWS:   rows = clamp_count(data[CNT_REG_W-1:0]);
				CFG_COLS:   cols = clamp_count(data[CNT_REG_W-1:0]);
				default:    return;
			endcase
			// any real register write aborts the matrix in progress
			restart();
		endfunction

		function void note_element(logic [ELEM_W-1:0] v);
			cell_result_t res;
			longint       goal;
			int           r;
			int           c;
			bit           hf;
			bit           vf;
			r    = cur_row;
			c    = cur_col;
			goal = target;
			store[r][c] = v;

			if (c == 0) begin
				row_sum   = 0;
				row_start = 0;
			end
			row_sum += v;
			// drop from the left until the window fits the target again
			while (row_sum > goal && row_start <= c) begin
				row_sum -= store[r][row_start];
				row_start++;
			end
			hf = (row_sum == goal) && (row_start <= c);

			if (r == 0) begin
				col_sum[c]   = 0;
				col_start[c] = 0;
			end
			col_sum[c] += v;
			while (col_sum[c] > goal && col_start[c] <= r) begin
				col_sum[c] -= store[col_start[c]][c];
				col_start[c]++;
			end
			vf = (col_sum[c] == goal) && (col_start[c] <= r);

			hits = hits + hf + vf;
			res.cell_row    = r[POS_OUT_W-1:0];
			res.cell_col    = c[POS_OUT_W-1:0];
			res.h_found     = hf;
			res.h_start_col = hf ? row_start[POS_OUT_W-1:0] : '0;
			res.v_found     = vf;
			res.v_start_row = vf ? col_start[c][POS_OUT_W-1:0] : '0;
			res.match_count = hits;
			res.last_cell   = (c + 1 >= cols) && (r + 1 >= rows);
			pending_q = {pending_q, res};

			if (res.last_cell) begin
				restart();
			end else if (c + 1 >= cols) begin
				cur_col = 0;
				cur_row = r + 1;
			end else begin
				cur_col = c + 1;
			end
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		task compare_field(string name, logic [15:0] want, logic [15:0] got, cell_result_t at);
			if (got !== want)
				report($sformatf("cell (%0d,%0d) %s expected %0d, got %0h",
					at.cell_row, at.cell_col, name, want, got));
		endtask

		task check_result(cell_result_t got);
			cell_result_t want;
			if (pending_q.size() == 0) begin
				report($sformatf("result word for cell (%0d,%0d) with none pending",
					got.cell_row, got.cell_col));
				return;
			end
			want = pending_q.pop_front();
			compare_field("cell_row", want.cell_row, got.cell_row, want);
			compare_field("cell_col", want.cell_col, got.cell_col, want);
			compare_field("h_found", want.h_found, got.h_found, want);
			compare_field("h_start_col", want.h_start_col, got.h_start_col, want);
			compare_field("v_found", want.v_found, got.v_found, want);
			compare_field("v_start_row", want.v_start_row, got.v_start_row, want);
			compare_field("match_count", want.match_count, got.match_count, want);
			compare_field("last_cell", want.last_cell, got.last_cell, want);
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	mlrs_elem_if   element_ch ();
	mlrs_result_if result_ch ();

	matrix_line_run_sum_search dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.element   (element_ch),
		.result    (result_ch)
	);

	run_sum_scoreboard board;
	bit                steady;
	int                choke_asked;
	int                choke_taken;
	int                hold_left;
	int                cycle_count;
	int                random_sent;

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// note inputs before checking results so a word never races its prediction
	always @(posedge clk) begin
		cell_result_t seen;
		if (arst_n === 1'b1 && element_ch.valid && element_ch.ready)
			board.note_element(element_ch.element_value);
		if (arst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready) begin
			seen.cell_row    = result_ch.cell_row;
			seen.cell_col    = result_ch.cell_col;
			seen.h_found     = result_ch.h_found;
			seen.h_start_col = result_ch.h_start_col;
			seen.v_found     = result_ch.v_found;
			seen.v_start_row = result_ch.v_start_row;
			seen.match_count = result_ch.match_count;
			seen.last_cell   = result_ch.last_cell;
			board.check_result(seen);
		end
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		result_ch.ready = 1'b0;
		hold_left = 0;
		choke_taken = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else if (choke_taken != choke_asked) begin
				choke_taken++;
				hold_left = HOLD_CYCLES - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	task automatic send_element(logic [ELEM_W-1:0] v);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			@(negedge clk);
			element_ch.valid <= 1'b0;
			element_ch.element_value <= ELEM_W'($urandom());
		end
		@(negedge clk);
		element_ch.valid <= 1'b1;
		element_ch.element_value <= v;
		@(posedge clk);
		while (!element_ch.ready)
			@(posedge clk);
	endtask

	// wait until every predicted word is back and the block sits idle
	task automatic drain();
		@(negedge clk);
		element_ch.valid <= 1'b0;
		while (board.pending_q.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		board.write_register(idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(logic [CFG_DATA_W-1:0] goal, logic [CFG_DATA_W-1:0] row_word,
			logic [CFG_DATA_W-1:0] col_word);
		write_register(CFG_TARGET, goal);
		write_register(CFG_ROWS, row_word);
		write_register(CFG_COLS, col_word);
	endtask

	function automatic logic [ELEM_W-1:0] pick_value(value_mix_t mix, int top);
		if ($urandom_range(0, 49) == 0)
			return '0;
		if (mix == MIX_SMALL)
			return ELEM_W'($urandom_range(1, top));
		if ($urandom_range(0, 9) < 6)
			return '1;
		return ELEM_W'($urandom_range(1, 16'hFFFF));
	endfunction

	// count register word with random upper bits; narrow keeps it at 1..4
	function automatic logic [CFG_DATA_W-1:0] count_word(bit narrow);
		int pick;
		int n;
		pick = $urandom_range(0, 99);
		if (narrow)
			n = $urandom_range(1, 4);
		else if (pick < 5)
			n = 0;
		else if (pick < 12)
			n = DIM_MAX;
		else if (pick < 17)
			n = $urandom_range(DIM_MAX + 1, 127);
		else if (pick < 30)
			n = $urandom_range(5, 8);
		else
			n = $urandom_range(1, 4);
		return ($urandom() & ~32'h7F) | n;
	endfunction

	initial begin
		int                    phase;
		int                    cells;
		int                    n_mat;
		int                    top;
		int                    part;
		value_mix_t            mix;
		logic [CFG_DATA_W-1:0] goal;
		logic [CFG_DATA_W-1:0] row_word;
		logic [CFG_DATA_W-1:0] col_word;
		logic [ELEM_W-1:0]     grid [12];

		board = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_TARGET;
		cfg_data = '0;
		element_ch.valid = 1'b0;
		element_ch.element_value = '0;
		steady = 1'b0;
		choke_asked = 0;
		random_sent = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings; a write to the empty index leaves the matrix open
		send_element(16'd1);
		send_element(16'd1);
		send_element(16'd2);
		drain();
		write_register(CFG_UNUSED, 32'h3F);
		send_element(16'hFFFF);
		drain();

		// 3x4 with runs both ways, an oversized element and a zero element
		configure(32'd10, 32'd3, 32'd4);
		grid = '{16'd3, 16'd7, 16'd11, 16'd10, 16'd7, 16'd2, 16'd1, 16'hFFFF,
			16'd0, 16'd1, 16'd9, 16'd10};
		foreach (grid[i])
			send_element(grid[i]);
		drain();

		// counts out of range: 0x80 and 0 both act as one; full-scale target
		configure(32'hFFFF_FFFF, 32'h80, 32'd0);
		send_element(16'hFFFF);
		send_element(16'h8000);
		drain();
		write_register(CFG_TARGET, 32'd0);
		send_element(16'd0);
		send_element(16'd5);
		drain();

		// abort a matrix part way through
		configure(32'd5, 32'd2, 32'd3);
		send_element(16'd5);
		drain();
		write_register(CFG_TARGET, 32'd1);
		send_element(16'd1);
		send_element(16'd1);
		send_element(16'd2);
		send_element(16'd1);
		drain();

		phase = 0;
		while (random_sent < RANDOM_ITEMS) begin
			steady = (phase == 0);
			if (phase == 1)
				choke_asked++;
			mix = ($urandom_range(0, 3) == 0) ? MIX_WIDE : MIX_SMALL;
			top = $urandom_range(2, 12);
			part = $urandom_range(0, 29);
			if (part == 0)
				goal = '0;
			else if (part == 1)
				goal = '1;
			else if (mix == MIX_SMALL)
				goal = $urandom_range(1, 4 * top);
			else
				goal = 65535 * $urandom_range(1, 3) +
					($urandom_range(0, 1) ? 0 : $urandom_range(1, 65535));
			row_word = count_word(1'b0);
			col_word = count_word(board.clamp_count(row_word[CNT_REG_W-1:0]) > 4);
			configure(goal, row_word, col_word);

			cells = board.rows * board.cols;
			n_mat = (cells > 64) ? 1 : $urandom_range(1, 3);
			if (steady || phase == 1)
				while (n_mat * cells < 150)
					n_mat++;
			repeat (n_mat * cells) begin
				send_element(pick_value(mix, top));
				random_sent++;
			end
			// leave a matrix open so the next write aborts it
			if (cells > 1 && $urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, cells - 1)) begin
					send_element(pick_value(mix, top));
					random_sent++;
				end
			drain();
			phase++;
		end
		steady = 1'b0;

		while (board.pending_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
